/* rtl/core/utf8v_pkg.sv */
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared constants, tables and types of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned BytesPerItemDef = 8;
  localparam int unsigned CtxDepth        = 3;
  localparam int unsigned ByteCountW      = 4;

  localparam logic [7:0] LeadMin   = 8'hC0;
  localparam logic [2:0] ThreeLead = 3'b111;

  // result of one transaction
  typedef struct packed {
    logic error_seen;
    logic done_res;
    logic valid_res;
  } result_t;

  // continuation bytes owed after a byte with this high nibble
  function automatic logic [1:0] lead_len(input logic [3:0] nib);
    logic [1:0] r;
    unique case (nib) inside
      4'hC, 4'hD: r = 2'd1;
      4'hE:       r = 2'd2;
      4'hF:       r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lo_bound(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx) inside
      4'd0:                   r = 8'h00;
      4'd1, 4'd2, 4'd3, 4'd5,
      4'd7:                   r = 8'h80;
      4'd4:                   r = 8'hA0;
      4'd6:                   r = 8'h90;
      4'd8:                   r = 8'hC2;
      default:                r = 8'hFF;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hi_bound(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx) inside
      4'd0:                         r = 8'h7F;
      4'd1, 4'd2, 4'd3, 4'd4, 4'd6: r = 8'hBF;
      4'd5:                         r = 8'h9F;
      4'd7:                         r = 8'h8F;
      4'd8:                         r = 8'hF4;
      default:                      r = 8'h00;
    endcase
    return r;
  endfunction

  // range adjustment after a previous byte of E0..FF, indexed by its low bits
  function automatic logic [2:0] shift_adj(input logic [4:0] pos);
    logic [2:0] r;
    unique case (pos) inside
      5'd0:         r = 3'd2;
      5'd13, 5'd16: r = 3'd3;
      5'd20:        r = 3'd4;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // continuation bytes still owed, seen from the three latest bytes
  function automatic logic [1:0] pending_idx(input logic [7:0] p0,
                                             input logic [7:0] p1,
                                             input logic [7:0] p2);
    logic [1:0] l1;
    logic [1:0] l2;
    l1 = lead_len(p1[7:4]);
    l2 = lead_len(p2[7:4]);
    return lead_len(p0[7:4])
         | ((l1 > 2'd1) ? l1 - 2'd1 : 2'd0)
         | ((l2 > 2'd2) ? l2 - 2'd2 : 2'd0);
  endfunction

endpackage

/* rtl/core/utf8v_lane.sv */
// ----------------------------------------------------------------------------
// utf8v_lane
// Range check of one stream byte against the three bytes before it.
// ----------------------------------------------------------------------------
module utf8v_lane (
  input  logic [7:0] cur_i,
  input  logic [7:0] prev0_i,
  input  logic [7:0] prev1_i,
  input  logic [7:0] prev2_i,
  output logic       bad_o
);
  import utf8v_pkg::*;

  logic [3:0] idx;

  always_comb begin
    idx = {(cur_i >= LeadMin), 1'b0, pending_idx(prev0_i, prev1_i, prev2_i)};
    // lead bytes E0, ED, F0 and F4 narrow the next range
    if (prev0_i[7:5] == ThreeLead) begin
      idx = idx + {1'b0, shift_adj(prev0_i[4:0])};
    end
    bad_o = (cur_i < lo_bound(idx)) || (cur_i > hi_bound(idx));
  end

endmodule

/* rtl/core/utf8v_core.sv */
// ----------------------------------------------------------------------------
// utf8v_core
// Word check: one lane per byte, carried byte context and sticky error.
// ----------------------------------------------------------------------------
module utf8v_core #(
  parameter int unsigned BytesPerItem = utf8v_pkg::BytesPerItemDef,
  parameter int unsigned CntW         = $clog2(BytesPerItem + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [8*BytesPerItem-1:0] data_i,
  input  logic [CntW-1:0]           cnt_i,
  input  logic                      last_i,
  output utf8v_pkg::result_t        res_o
);
  import utf8v_pkg::*;

  localparam int unsigned ExtLen = BytesPerItem + CtxDepth;

  // index 0 is the most recent byte
  logic [7:0] ctx_q [CtxDepth];
  logic [7:0] ctx_d [CtxDepth];
  logic       sticky_q, sticky_d;

  logic [7:0]              ext [ExtLen];
  logic [BytesPerItem-1:0] bad;
  logic [7:0]              nctx [CtxDepth];
  logic                    word_err;
  logic                    final_err;

  // oldest context byte first, then the word bytes in stream order
  always_comb begin
    for (int i = 0; i < CtxDepth; i++) begin
      ext[i] = ctx_q[CtxDepth-1-i];
    end
    for (int j = 0; j < BytesPerItem; j++) begin
      ext[CtxDepth+j] = data_i[8*j +: 8];
    end
  end

  for (genvar k = 0; k < BytesPerItem; k++) begin : g_lane
    utf8v_lane u_lane (
      .cur_i  (ext[k+3]),
      .prev0_i(ext[k+2]),
      .prev1_i(ext[k+1]),
      .prev2_i(ext[k]),
      .bad_o  (bad[k])
    );
  end

  always_comb begin
    word_err = sticky_q;
    for (int k = 0; k < BytesPerItem; k++) begin
      if ((CntW'(k) < cnt_i) && bad[k]) begin
        word_err = 1'b1;
      end
    end
    // the three latest valid bytes become the new context
    for (int i = 0; i < CtxDepth; i++) begin
      nctx[i] = ctx_q[i];
    end
    for (int j = 0; j <= BytesPerItem; j++) begin
      if (cnt_i == CntW'(j)) begin
        for (int i = 0; i < CtxDepth; i++) begin
          nctx[i] = ext[j+CtxDepth-1-i];
        end
      end
    end
    final_err = word_err || (pending_idx(nctx[0], nctx[1], nctx[2]) != 2'd0);

    res_o.error_seen = last_i ? final_err : word_err;
    res_o.done_res   = last_i;
    res_o.valid_res  = last_i && !final_err;

    for (int i = 0; i < CtxDepth; i++) begin
      ctx_d[i] = last_i ? 8'h00 : nctx[i];
    end
    sticky_d = last_i ? 1'b0 : word_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CtxDepth; i++) begin
        ctx_q[i] <= 8'h00;
      end
      sticky_q <= 1'b0;
    end else if (adv_i) begin
      ctx_q    <= ctx_d;
      sticky_q <= sticky_d;
    end
  end

endmodule

/* rtl/core/utf8_stream_validator_unit.sv */
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit
// UTF-8 stream validator, up to BYTES_PER_ITEM bytes per word.
// ----------------------------------------------------------------------------
// Accepts one word per clock cycle while the result side does not stall,
// and returns one result per word through the input register and then the
// result register. All bytes of a word are checked in parallel lanes; the
// cycle is set by the path from the carried three-byte context through the
// per-byte range lookup and the final unfinished-sequence check into the
// sticky flag and result register. The error flag is sticky until the word
// marked last, whose result carries the verdict; that word also clears the
// context and the flag. Counts above BYTES_PER_ITEM saturate.
module utf8_stream_validator_unit #(
  parameter int unsigned BYTES_PER_ITEM = utf8v_pkg::BytesPerItemDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [8*BYTES_PER_ITEM-1:0]           data_word_i,
  input  logic [utf8v_pkg::ByteCountW-1:0]      byte_count_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  error_seen_o,
  output logic                                  done_res_o,
  output logic                                  valid_res_o
);
  import utf8v_pkg::*;

  localparam int unsigned CntW = $clog2(BYTES_PER_ITEM + 1);

  logic                        s1_vld_q;
  logic [8*BYTES_PER_ITEM-1:0] s1_data_q;
  logic [CntW-1:0]             s1_cnt_q;
  logic                        s1_last_q;
  logic [CntW-1:0]             cnt_sat;

  logic    out_vld_q;
  result_t out_res_q;
  result_t core_res;

  logic out_free;
  logic s1_adv;
  logic in_xact;

  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_adv     = s1_vld_q && out_free;
  assign in_ready_o = !s1_vld_q || out_free;
  assign in_xact    = in_valid_i && in_ready_o;

  assign cnt_sat = (byte_count_i > ByteCountW'(BYTES_PER_ITEM))
                 ? CntW'(BYTES_PER_ITEM) : byte_count_i[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xact) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      s1_data_q <= data_word_i;
      s1_cnt_q  <= cnt_sat;
      s1_last_q <= last_i;
    end
    if (s1_adv) begin
      out_res_q <= core_res;
    end
  end

  utf8v_core #(
    .BytesPerItem(BYTES_PER_ITEM),
    .CntW        (CntW)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (s1_adv),
    .data_i(s1_data_q),
    .cnt_i (s1_cnt_q),
    .last_i(s1_last_q),
    .res_o (core_res)
  );

  assign out_valid_o  = out_vld_q;
  assign error_seen_o = out_res_q.error_seen;
  assign done_res_o   = out_res_q.done_res;
  assign valid_res_o  = out_res_q.valid_res;

endmodule

/* test/utf8_stream_validator_unit_tb.sv */
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit_tb
// Self-checking bench for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
// Directed words hit overlong forms, surrogates, out-of-range code points,
// bad lead bytes, zero and oversized counts and sequences left open at the
// end of a string. Then random strings follow, mostly well-formed UTF-8 cut
// into words at random points, some of them damaged and some pure noise.
// A bit-level predictor runs on every accepted word, and each result is
// compared in order. Both handshakes idle at random, and the result side
// holds off once for a long stretch so that the input backs up.
module utf8_stream_validator_unit_tb;
  import utf8v_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        fin;
  } word_t;

  // continuation bytes owed after a byte with this high nibble
  localparam logic [1:0] SEQ_LEN [16] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3
  };
  localparam logic [7:0] LO_LIM [16] = '{
    8'h00, 8'h80, 8'h80, 8'h80, 8'hA0, 8'h80, 8'h90, 8'h80,
    8'hC2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };
  localparam logic [7:0] HI_LIM [16] = '{
    8'h7F, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h9F, 8'hBF, 8'h8F,
    8'hF4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  // range shift after a previous byte of E0..FF
  localparam logic [3:0] RANGE_SHIFT [32] = '{
    4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0,
    4'd3, 4'd0, 4'd0, 4'd0, 4'd4, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };
  localparam logic [7:0] EDGE_BYTES [13] = '{
    8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hC2, 8'hDF, 8'hE0,
    8'hED, 8'hEF, 8'hF0, 8'hF4, 8'hF5, 8'hFF
  };
  localparam int NUM_WORDS = 1850;
  localparam int HOLD_CYCLES = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [63:0]           data_word_i;
  logic [ByteCountW-1:0] byte_count_i;
  logic                  last_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  error_seen_o;
  logic                  done_res_o;
  logic                  valid_res_o;

  word_t      word_q[$];
  result_t    verdict_q[$];
  logic [7:0] str_q[$];

  // predictor state: recent stream bytes, index 0 newest, and the sticky flag
  logic [7:0] recent [3];
  logic       sticky_bad;

  word_t nxt;
  int    words_sent;
  int    results_seen;
  int    strings_ok;
  int    strings_bad;
  int    err_cnt;
  int    hold_left;
  bit    held;

  utf8_stream_validator_unit #(
    .BYTES_PER_ITEM(8)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .error_seen_o(error_seen_o),
    .done_res_o  (done_res_o),
    .valid_res_o (valid_res_o)
  );

  function automatic logic [1:0] owed_bytes();
    logic [1:0] l0;
    logic [1:0] l1;
    logic [1:0] l2;
    l0 = SEQ_LEN[recent[0][7:4]];
    l1 = SEQ_LEN[recent[1][7:4]];
    l2 = SEQ_LEN[recent[2][7:4]];
    return l0 | ((l1 > 2'd1) ? l1 - 2'd1 : 2'd0) | ((l2 > 2'd2) ? l2 - 2'd2 : 2'd0);
  endfunction

  // advances the predictor over one word and returns the result it owes
  function automatic result_t scan_word(logic [63:0] d, logic [3:0] c, logic fin);
    result_t    r;
    int         n;
    logic [7:0] b;
    logic [7:0] pos;
    logic [3:0] idx;
    n = (c > 4'd8) ? 8 : int'(c);
    for (int k = 0; k < n; k++) begin
      b = d[8*k +: 8];
      idx = (b >= 8'hC0) ? 4'd8 : 4'd0;
      idx = idx | {2'b00, owed_bytes()};
      pos = recent[0] - 8'hE0;
      if (pos < 8'd32) begin
        idx = idx + RANGE_SHIFT[pos[4:0]];
      end
      if (b < LO_LIM[idx] || b > HI_LIM[idx]) begin
        sticky_bad = 1'b1;
      end
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = b;
    end
    if (fin) begin
      if (owed_bytes() != 2'd0) begin
        sticky_bad = 1'b1;
      end
      r.error_seen = sticky_bad;
      r.done_res   = 1'b1;
      r.valid_res  = !sticky_bad;
      recent     = '{8'h00, 8'h00, 8'h00};
      sticky_bad = 1'b0;
    end else begin
      r.error_seen = sticky_bad;
      r.done_res   = 1'b0;
      r.valid_res  = 1'b0;
    end
    return r;
  endfunction

  task automatic push_word(input logic [63:0] d, input logic [3:0] c, input logic fin);
    word_t w;
    w.data = d;
    w.cnt  = c;
    w.fin  = fin;
    word_q.push_back(w);
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      str_q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      str_q.push_back({3'b110, cp[10:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      str_q.push_back({4'b1110, cp[15:12]});
      str_q.push_back({2'b10, cp[11:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end else begin
      str_q.push_back({5'b11110, cp[20:18]});
      str_q.push_back({2'b10, cp[17:12]});
      str_q.push_back({2'b10, cp[11:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end
  endtask

  // one random string, cut into words at random points
  task automatic gen_string();
    int          n;
    int          sel;
    int          pos;
    int          take;
    int          rem;
    logic [20:0] cp;
    logic [63:0] d;
    logic [3:0]  c;
    bit          tail_empty;
    str_q.delete();
    if ($urandom_range(0, 99) < 6) begin
      n = $urandom_range(1, 10);
      repeat (n) str_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          cp = 21'($urandom_range(0, 8'h7F));
        end else if (sel < 60) begin
          if ($urandom_range(0, 4) == 0) cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
          else cp = 21'($urandom_range(16'h80, 16'h7FF));
        end else if (sel < 85) begin
          case ($urandom_range(0, 9))
            0:       cp = 21'h800;
            1:       cp = 21'hFFFF;
            2:       cp = 21'hD7FF;
            3:       cp = 21'hE000;
            default: cp = 21'($urandom_range(16'h800, 16'hFFFF));
          endcase
          // keep out of the surrogate block
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;
        end else begin
          case ($urandom_range(0, 9))
            0:       cp = 21'h10000;
            1:       cp = 21'h10FFFF;
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
          endcase
        end
        add_code_point(cp);
      end
      if ($urandom_range(0, 99) < 25) begin
        pos = $urandom_range(0, str_q.size() - 1);
        case ($urandom_range(0, 3))
          0: str_q[pos] = 8'($urandom_range(0, 255));
          1: str_q[pos] = EDGE_BYTES[$urandom_range(0, 12)];
          2: str_q.delete(str_q.size() - 1);
          default: str_q.insert(pos, EDGE_BYTES[$urandom_range(0, 12)]);
        endcase
      end
    end
    tail_empty = (str_q.size() == 0) || ($urandom_range(0, 9) == 0);
    pos = 0;
    while (pos < str_q.size()) begin
      if ($urandom_range(0, 19) == 0) begin
        push_word({$urandom, $urandom}, 4'd0, 1'b0);
      end
      rem  = str_q.size() - pos;
      take = $urandom_range(1, (rem < 8) ? rem : 8);
      d    = {$urandom, $urandom};
      for (int k = 0; k < take; k++) d[8*k +: 8] = str_q[pos+k];
      c = 4'(take);
      if (take == 8 && $urandom_range(0, 3) == 0) c = 4'($urandom_range(9, 15));
      pos += take;
      push_word(d, c, (pos == str_q.size()) && !tail_empty);
    end
    if (tail_empty) begin
      push_word({$urandom, $urandom}, 4'd0, 1'b1);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: offers queued words, idles at random outside the calm window
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        verdict_q.push_back(scan_word(data_word_i, byte_count_i, last_i));
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() > 0 &&
            ((words_sent >= 600 && words_sent < 1000) || $urandom_range(0, 99) >= 8)) begin
          nxt = word_q.pop_front();
          in_valid_i   <= 1'b1;
          data_word_i  <= nxt.data;
          byte_count_i <= nxt.cnt;
          last_i       <= nxt.fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transaction against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (error_seen_o !== want.error_seen) begin
            $error("error_seen: expected %0b, actual %0b", want.error_seen, error_seen_o);
            err_cnt++;
          end
          if (done_res_o !== want.done_res) begin
            $error("done_res: expected %0b, actual %0b", want.done_res, done_res_o);
            err_cnt++;
          end
          if (valid_res_o !== want.valid_res) begin
            $error("valid_res: expected %0b, actual %0b", want.valid_res, valid_res_o);
            err_cnt++;
          end
          if (want.done_res && want.valid_res) strings_ok++;
          else if (want.done_res) strings_bad++;
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held && results_seen >= 400) begin
        // long back-pressure so the input side fills and stalls
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (results_seen >= 600 && results_seen < 1000) ||
                       ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_i       = 1'b0;
    out_ready_i  = 1'b0;
    recent       = '{8'h00, 8'h00, 8'h00};
    sticky_bad   = 1'b0;
    words_sent   = 0;
    results_seen = 0;
    strings_ok   = 0;
    strings_bad  = 0;
    err_cnt      = 0;
    hold_left    = 0;
    held         = 1'b0;

    // byte 0 of each word sits in the low bits
    push_word(64'h0000_0000_0000_0000, 4'd8, 1'b0);
    push_word(64'h7F7F_7F7F_7F7F_7F7F, 4'd8, 1'b1);
    push_word(64'h4180_A0E0_BFDF_80C2, 4'd8, 1'b0);
    push_word(64'hBFBF_8FF4_8080_90F0, 4'd8, 1'b1);
    push_word(64'h0000_0000_0000_80C0, 4'd2, 1'b1);  // overlong two-byte
    push_word(64'h0000_0000_0080_80E0, 4'd3, 1'b1);  // overlong three-byte
    push_word(64'h0000_0000_0080_A0ED, 4'd3, 1'b1);  // surrogate
    push_word(64'h0000_0000_00BF_9FED, 4'd3, 1'b1);
    push_word(64'h0000_0000_8080_90F4, 4'd4, 1'b1);  // above U+10FFFF
    push_word(64'h0000_0000_8080_80F0, 4'd4, 1'b1);  // overlong four-byte
    push_word(64'h0000_0000_8080_80F5, 4'd4, 1'b1);
    push_word(64'h0000_0000_00BF_C1FF, 4'd3, 1'b1);
    push_word(64'h0000_0000_0000_0080, 4'd1, 1'b1);  // stray continuation
    push_word(64'h0000_0000_0080_C2C2, 4'd3, 1'b1);  // lead where continuation due
    push_word(64'h4141_4141_4141_4141, 4'd15, 1'b0); // count saturates
    push_word(64'h989F_F0AC_82E2_A9C3, 4'd9, 1'b1);  // ends mid sequence
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
    push_word(64'h0000_0000_0000_0000, 4'd0, 1'b1);
    push_word(64'hFFFF_FFFF_FFFF_A9C3, 4'd2, 1'b1);  // junk above count
    push_word(64'hFFFF_FFFF_FFFF_82E2, 4'd2, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);  // empty word closes open sequence
    push_word(64'h8080_8080_8080_80F0, 4'd1, 1'b0);
    push_word(64'h0000_0000_0000_009F, 4'd1, 1'b0);
    push_word(64'h0000_0000_0000_8098, 4'd2, 1'b1);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
    while (word_q.size() < NUM_WORDS) gen_string();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d words driven, %0d results checked", words_sent, results_seen);
    $display("%0d strings accepted as well-formed, %0d rejected", strings_ok, strings_bad);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout: %0d results still pending", verdict_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
